// ===== hw/rtl/rc5_pkg.sv =====
// Shared types and constants of the RC5 infrared receiver.
package rc5_pkg;

  localparam int unsigned INTERVAL_W = 8;
  localparam int unsigned FULL_W     = 8;
  localparam int unsigned HALF_W     = 7;
  localparam int unsigned TOL_W      = 6;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned CFG_DATA_W = 8;
  // Window sums need one bit above the widest operand.
  localparam int unsigned SUM_W      = 9;

  // Frame lengths in half bits: 26 means the last half bit was the idle level.
  localparam logic [CNT_W-1:0] HALVES_SHORT = CNT_W'(26);
  localparam logic [CNT_W-1:0] HALVES_LONG  = CNT_W'(27);

  typedef enum logic {
    OP_EDGE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_FULL_BIT  = 2'd1,
    CFG_HALF_BIT  = 2'd2,
    CFG_TOLERANCE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] start_bits;
    logic       toggle;
    logic [4:0] address;
    logic [5:0] command;
  } rc5_frame_t;

endpackage

// ===== hw/rtl/rc5_if.sv =====
// Handshake channels of the RC5 receiver: input events, frames and config writes.
interface rc5_in_if;
  logic                             valid;
  logic                             ready;
  rc5_pkg::op_t                     operation;
  logic [rc5_pkg::INTERVAL_W-1:0]   interval;

  modport source (output valid, output operation, output interval, input ready);
  modport sink   (input valid, input operation, input interval, output ready);
endinterface

interface rc5_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] start_bits;
  logic       toggle;
  logic [4:0] address;
  logic [5:0] command;

  modport source (output valid, output start_bits, output toggle, output address,
                  output command, input ready);
  modport sink   (input valid, input start_bits, input toggle, input address,
                  input command, output ready);
endinterface

interface rc5_cfg_if;
  logic                             valid;
  logic                             ready;
  rc5_pkg::cfg_idx_t                index;
  logic [rc5_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rc5_ir_receiver_decoder.sv =====
// RC5 inverted-Manchester decoder driven by edge and timeout events.
// Latency: a timeout item that closes a valid frame shows its frame on out_ch
//   in the cycle after it is accepted; edge items give no frame.
// Throughput: one item per cycle; the frame register stalls input only while
//   a frame is held and out_ch.ready is low.
// Reset (rst_n low, synchronous): counters, shift word and lockout cleared,
//   configuration back to enable=1, full=28, half=14, tolerance=5.
module rc5_ir_receiver_decoder (
  input  logic            clk,
  input  logic            rst_n,
  rc5_in_if.sink          in_ch,
  rc5_out_if.source       out_ch,
  rc5_cfg_if.sink         cfg_ch
);

  logic                           enable_r;
  logic [rc5_pkg::FULL_W-1:0]     full_ticks_r;
  logic [rc5_pkg::HALF_W-1:0]     half_ticks_r;
  logic [rc5_pkg::TOL_W-1:0]      tol_ticks_r;

  logic [rc5_pkg::CNT_W-1:0]      edge_cnt_r, edge_cnt_nxt;
  logic [rc5_pkg::CNT_W-1:0]      half_cnt_r, half_cnt_nxt;
  logic [rc5_pkg::WORD_W-1:0]     shift_r, shift_nxt;
  logic                           lockout_r, lockout_nxt;

  logic                           out_valid_r, out_valid_nxt;
  rc5_pkg::rc5_frame_t            frame_r;
  rc5_pkg::rc5_frame_t            frame_nxt;
  logic                           emit;

  logic                           in_ready;
  logic                           accept;
  logic [rc5_pkg::SUM_W-1:0]      iv_plus_tol;
  logic [rc5_pkg::SUM_W-1:0]      half_plus_tol;
  logic [rc5_pkg::SUM_W-1:0]      full_plus_tol;
  logic                           half_match;
  logic                           full_match;
  logic [rc5_pkg::WORD_W-1:0]     word_out;

  assign in_ready     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = in_ready;
  assign accept       = in_ch.valid && in_ready;
  assign cfg_ch.ready = 1'b1;

  // n - tol < iv < n + tol, rewritten without negative values
  assign iv_plus_tol   = rc5_pkg::SUM_W'(in_ch.interval) + rc5_pkg::SUM_W'(tol_ticks_r);
  assign half_plus_tol = rc5_pkg::SUM_W'(half_ticks_r) + rc5_pkg::SUM_W'(tol_ticks_r);
  assign full_plus_tol = rc5_pkg::SUM_W'(full_ticks_r) + rc5_pkg::SUM_W'(tol_ticks_r);
  assign half_match = (iv_plus_tol > rc5_pkg::SUM_W'(half_ticks_r)) &&
                      (rc5_pkg::SUM_W'(in_ch.interval) < half_plus_tol);
  assign full_match = (iv_plus_tol > rc5_pkg::SUM_W'(full_ticks_r)) &&
                      (rc5_pkg::SUM_W'(in_ch.interval) < full_plus_tol);

  // Append the idle half bit when the frame ended on a short count.
  assign word_out = (half_cnt_r == rc5_pkg::HALVES_SHORT) ?
                    {shift_r[rc5_pkg::WORD_W-2:0], 1'b0} : shift_r;

  always_comb begin
    edge_cnt_nxt = edge_cnt_r;
    half_cnt_nxt = half_cnt_r;
    shift_nxt    = shift_r;
    lockout_nxt  = lockout_r;
    emit         = 1'b0;
    if (accept) begin
      if (in_ch.operation == rc5_pkg::OP_EDGE) begin
        if (enable_r && !lockout_r) begin
          if (edge_cnt_r == '0) begin
            shift_nxt    = '0;
            edge_cnt_nxt = edge_cnt_r + 1'b1;
          end else if (half_match) begin
            half_cnt_nxt = half_cnt_r + 1'b1;
            if (!half_cnt_r[0]) begin
              shift_nxt = {shift_r[rc5_pkg::WORD_W-2:0], edge_cnt_r[0]};
            end
            edge_cnt_nxt = edge_cnt_r + 1'b1;
          end else if (full_match) begin
            // two half bits: exactly one of them lands on an odd count
            half_cnt_nxt = half_cnt_r + 2'd2;
            shift_nxt    = {shift_r[rc5_pkg::WORD_W-2:0], edge_cnt_r[0]};
            edge_cnt_nxt = edge_cnt_r + 1'b1;
          end else begin
            lockout_nxt  = 1'b1;
            half_cnt_nxt = '0;
          end
        end
      end else begin
        shift_nxt    = word_out;
        emit         = (half_cnt_r == rc5_pkg::HALVES_SHORT) ||
                       (half_cnt_r == rc5_pkg::HALVES_LONG);
        half_cnt_nxt = '0;
        edge_cnt_nxt = '0;
        if (enable_r) begin
          lockout_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    frame_nxt.start_bits = word_out[13:12];
    frame_nxt.toggle     = word_out[11];
    frame_nxt.address    = word_out[10:6];
    frame_nxt.command    = word_out[5:0];
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_cnt_r  <= '0;
      half_cnt_r  <= '0;
      shift_r     <= '0;
      lockout_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      edge_cnt_r  <= edge_cnt_nxt;
      half_cnt_r  <= half_cnt_nxt;
      shift_r     <= shift_nxt;
      lockout_r   <= lockout_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_r <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      full_ticks_r <= rc5_pkg::FULL_W'(28);
      half_ticks_r <= rc5_pkg::HALF_W'(14);
      tol_ticks_r  <= rc5_pkg::TOL_W'(5);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rc5_pkg::CFG_ENABLE:    enable_r     <= cfg_ch.data[0];
        rc5_pkg::CFG_FULL_BIT:  full_ticks_r <= cfg_ch.data[rc5_pkg::FULL_W-1:0];
        rc5_pkg::CFG_HALF_BIT:  half_ticks_r <= cfg_ch.data[rc5_pkg::HALF_W-1:0];
        rc5_pkg::CFG_TOLERANCE: tol_ticks_r  <= cfg_ch.data[rc5_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.start_bits = frame_r.start_bits;
  assign out_ch.toggle     = frame_r.toggle;
  assign out_ch.address    = frame_r.address;
  assign out_ch.command    = frame_r.command;

endmodule

// ===== hw/rtl/rc5_checker.sv =====
// Port-level checks of the RC5 receiver, bound to the top level.
module rc5_port_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_operation,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready
);

  // A held frame stays offered until taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("frame dropped while stalled");

  // A new frame appears only after an accepted timeout item.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_operation))
    else $error("frame without a timeout item");

  // An edge item never produces a frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_operation && (!out_valid || out_ready) |=> !out_valid)
    else $error("frame after an edge item");

  // Reset empties the frame register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("frame valid after reset");

  assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port stalled");

endmodule

bind rc5_ir_receiver_decoder rc5_port_checker u_rc5_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_operation (in_ch.operation),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .cfg_ready    (cfg_ch.ready)
);

// ===== tb/rc5_checker.sv =====
`timescale 1ns / 100ps
// Frame checker of the RC5 receiver: mirrors the decoder from accepted items and checks frames.
module rc5_checker (
  input  logic clk,
  input  logic rst_n,
  rc5_in_if    in_mon,
  rc5_out_if   out_mon,
  rc5_cfg_if   cfg_mon,
  output int   errors,
  output int   pending
);
  import rc5_pkg::*;

  rc5_frame_t frames_due[$];
  int         fail_total;

  logic              rx_enable;
  logic [FULL_W-1:0] full_ticks;
  logic [HALF_W-1:0] half_ticks;
  logic [TOL_W-1:0]  tol_ticks;
  logic [CNT_W-1:0]  edge_cnt;
  logic [CNT_W-1:0]  half_cnt;
  logic [WORD_W-1:0] rx_word;
  logic              locked;

  // Strict window, signed: a nominal below the tolerance opens the lower bound.
  function automatic bit near_ticks(logic [INTERVAL_W-1:0] iv, int nominal);
    int tol;
    tol = int'(tol_ticks);
    return int'(iv) > nominal - tol && int'(iv) < nominal + tol;
  endfunction

  task automatic apply_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_ENABLE:    rx_enable  = value[0];
      CFG_FULL_BIT:  full_ticks = value[FULL_W-1:0];
      CFG_HALF_BIT:  half_ticks = value[HALF_W-1:0];
      CFG_TOLERANCE: tol_ticks  = value[TOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic decode_edge(logic [INTERVAL_W-1:0] iv);
    int halves;
    if (!rx_enable || locked) return;
    if (edge_cnt == '0) begin
      rx_word = '0;
    end else begin
      // half-bit window wins where the two overlap
      if (near_ticks(iv, int'(half_ticks))) begin
        halves = 1;
      end else if (near_ticks(iv, int'(full_ticks))) begin
        halves = 2;
      end else begin
        // drop the frame, keep the edge count
        locked   = 1'b1;
        half_cnt = '0;
        return;
      end
      repeat (halves) begin
        half_cnt = half_cnt + 1'b1;
        if (half_cnt[0]) rx_word = {rx_word[WORD_W-2:0], edge_cnt[0]};
      end
    end
    edge_cnt = edge_cnt + 1'b1;
  endtask

  task automatic decode_timeout();
    if (half_cnt == HALVES_SHORT) rx_word = rx_word << 1;
    if (half_cnt == HALVES_SHORT || half_cnt == HALVES_LONG) begin
      frames_due.push_back(rc5_frame_t'(rx_word[$bits(rc5_frame_t)-1:0]));
    end
    half_cnt = '0;
    edge_cnt = '0;
    if (rx_enable) locked = 1'b0;
  endtask

  task automatic report(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_total++;
    end
  endtask

  task automatic check_frame();
    rc5_frame_t want;
    if (frames_due.size() == 0) begin
      $display("%0t: unexpected frame, expected none, actual %0d/%0d/%0d/%0d", $time,
               out_mon.start_bits, out_mon.toggle, out_mon.address, out_mon.command);
      fail_total++;
      return;
    end
    want = frames_due.pop_front();
    report("start_bits", want.start_bits, out_mon.start_bits);
    report("toggle", want.toggle, out_mon.toggle);
    report("address", want.address, out_mon.address);
    report("command", want.command, out_mon.command);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frames_due.delete();
      fail_total = 0;
      rx_enable  = 1'b1;
      full_ticks = 28;
      half_ticks = 14;
      tol_ticks  = 5;
      edge_cnt   = '0;
      half_cnt   = '0;
      rx_word    = '0;
      locked     = 1'b0;
    end else begin
      // a frame leaves no earlier than the cycle after its timeout, so check first
      if (out_mon.valid && out_mon.ready) check_frame();
      if (cfg_mon.valid && cfg_mon.ready) apply_cfg(cfg_mon.index, cfg_mon.data);
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_EDGE) begin
          decode_edge(in_mon.interval);
        end else begin
          decode_timeout();
        end
      end
    end
    errors  <= fail_total;
    pending <= frames_due.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the RC5 receiver testbench: clock, reset, event stimulus and verdict.
module tb;
  import rc5_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int HOLD_CYCLES  = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rc5_in_if  in_ch();
  rc5_out_if out_ch();
  rc5_cfg_if cfg_ch();

  int errors;
  int pending;

  int cur_full = 28;
  int cur_half = 14;
  int cur_tol  = 5;
  int items_sent = 0;
  bit in_gaps  = 1'b1;
  bit out_gaps = 1'b1;
  int hold_requests = 0;

  always #4 clk = ~clk;

  rc5_ir_receiver_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rc5_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .cfg_mon (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  // Interval for one or two half bits, jittered inside the current window when the tolerance is nonzero.
  function automatic logic [INTERVAL_W-1:0] pick_ticks(int halves);
    int nominal, span, v;
    nominal = (halves == 1) ? cur_half : cur_full;
    span    = (cur_tol > 0) ? cur_tol - 1 : 0;
    v = nominal + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return INTERVAL_W'(v);
  endfunction

  task automatic send_event(op_t op, logic [INTERVAL_W-1:0] iv);
    if (in_gaps) begin
      while ($urandom_range(0, 99) < 25) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.interval  <= iv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Lead edge, then intervals adding up to the wanted half-bit count, then timeout.
  task automatic send_frame(int target, int bad_at, logic [INTERVAL_W-1:0] lead);
    int sum, step, idx;
    send_event(OP_EDGE, lead);
    sum = 0;
    idx = 0;
    while (sum < target) begin
      step = (sum + 2 <= target && $urandom_range(0, 1) == 1) ? 2 : 1;
      if (idx == bad_at) begin
        send_event(OP_EDGE, INTERVAL_W'($urandom_range(0, 255)));
      end else begin
        send_event(OP_EDGE, pick_ticks(step));
      end
      sum += step;
      idx++;
    end
    send_event(OP_TIMEOUT, INTERVAL_W'($urandom_range(0, 255)));
  endtask

  task automatic run_sequence();
    int kind, n;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      send_frame(($urandom_range(0, 1) == 1) ? 26 : 27, -1,
                 INTERVAL_W'($urandom_range(0, 255)));
    end else if (kind < 75) begin
      send_frame($urandom_range(20, 30), -1, INTERVAL_W'($urandom_range(0, 255)));
    end else if (kind < 85) begin
      send_frame(27, $urandom_range(0, 12), INTERVAL_W'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) send_event(op_t'($urandom_range(0, 1)), INTERVAL_W'($urandom_range(0, 255)));
    end
  endtask

  // Hold input until every frame is out, then let any edge still in flight settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int en, int full, int half, int tol);
    drain();
    write_reg(CFG_ENABLE, CFG_DATA_W'(en));
    write_reg(CFG_FULL_BIT, CFG_DATA_W'(full));
    write_reg(CFG_HALF_BIT, CFG_DATA_W'(half));
    write_reg(CFG_TOLERANCE, CFG_DATA_W'(tol));
    cur_full = full;
    cur_half = half;
    cur_tol  = tol;
  endtask

  // Result receiver: random back-pressure, plus a long hold-off on request.
  initial begin
    int seen_holds;
    seen_holds = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen_holds) begin
        seen_holds = hold_requests;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= !out_gaps || $urandom_range(0, 99) >= 25;
    end
  end

  initial begin
    int phase, quota, phase_end, h;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_EDGE;
    in_ch.interval  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_ENABLE;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle timeout, full frame with widest lead, bad interval and lockout
    send_event(OP_TIMEOUT, 8'd0);
    send_frame(27, -1, 8'hff);
    send_event(OP_EDGE, 8'd0);
    send_event(OP_EDGE, 8'd0);
    send_event(OP_EDGE, pick_ticks(1));
    send_event(OP_TIMEOUT, 8'hff);

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      // no idling on either side during the second phase
      in_gaps = (phase != 1);
      out_gaps <= (phase != 1);
      quota = 150;
      case (phase)
        0: configure(1, 28, 14, 5);
        1: configure(1, 200, 100, 50);
        2: configure(1, 4, 2, 1);
        3: begin
          quota = 60;
          configure(1, 4, 2, 0);
        end
        4: configure(1, 28, 14, 50);
        5: begin
          quota = 60;
          // leave the receiver locked out, then disable it
          send_event(OP_EDGE, 8'd0);
          send_event(OP_EDGE, 8'hff);
          configure(0, 28, 14, 5);
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            configure(1, $urandom_range(4, 200), $urandom_range(2, 100), $urandom_range(0, 50));
          end else begin
            h = $urandom_range(2, 100);
            configure(1, 2 * h, h, $urandom_range(1, (h / 2 < 50) ? h / 2 : 50));
          end
        end
      endcase

      if (phase == 0) begin
        // wrap the edge count to zero while the half-bit count is back on zero
        send_event(OP_EDGE, 8'd0);
        repeat (254) send_event(OP_EDGE, pick_ticks(1));
        send_event(OP_EDGE, pick_ticks(2));
        send_frame(27, -1, INTERVAL_W'($urandom_range(0, 255)));
        drain();
        // long receiver hold-off while frames keep coming
        hold_requests <= hold_requests + 1;
        repeat (6) send_frame(27, -1, INTERVAL_W'($urandom_range(0, 255)));
        drain();
      end

      phase_end = items_sent + quota;
      while (items_sent < phase_end) run_sequence();
      phase++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
